@@ design/mbm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared codes, constants and control structs for the bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package mbm_pkg;

  // access kinds
  localparam logic [1:0] MODE_CPU_RD = 2'd0;
  localparam logic [1:0] MODE_CPU_WR = 2'd1;
  localparam logic [1:0] MODE_PPU_PAT = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  // target memories
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_PRG_ROM = 3'd1;
  localparam logic [2:0] TGT_PRG_RAM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;
  localparam logic [2:0] TGT_NT_RAM = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_ROM_BANKS = 2'd0;
  localparam logic [1:0] CFG_CHR_ROM_KIB = 2'd1;
  localparam logic [1:0] CFG_PRG_BANK_MOD = 2'd2;
  localparam logic [1:0] CFG_CHR_BANK_MOD = 2'd3;

  // register-write windows, address bits 15:13
  localparam logic [2:0] WIN_BANK = 3'b100;
  localparam logic [2:0] WIN_MIRROR = 3'b101;
  localparam logic [2:0] WIN_IRQ_LATCH = 3'b110;
  localparam logic [2:0] WIN_IRQ_EN = 3'b111;

  localparam logic [8:0] IRQ_DOT = 9'd260;
  localparam logic [8:0] VBL_FIRST = 9'd240;
  localparam logic [8:0] VBL_LAST = 9'd260;
  localparam logic [6:0] PRG_BANKS_MAX = 7'd64;

  localparam int REM_STEPS = 8;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the input transfer
    logic exec;       // commit a plain item and load the output
    logic rem_start;  // start the bank-number remainder
    logic rem_finish; // store the bank number and load the output
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bank_write;
    logic rem_done;
  } sts_t;

endpackage
`default_nettype wire

@@ design/mbm_rem.sv @@
// ----------------------------------------------------------------------------
// mbm_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_rem (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [8:0] divisor,
  output logic            done,
  output logic [7:0]      remainder
);

  localparam int REM_STEPS = mbm_pkg::REM_STEPS;

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [8:0] dsr_r, dsr_nxt;
  logic [9:0] trial;

  // one shift and conditional subtract per step
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    trial = {rem_r, dvd_r[7]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt = '0;
      rem_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 9'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[8:0];
      end
      dvd_nxt = {dvd_r[6:0], 1'b0};
      cnt_nxt = 3'(cnt_r + 3'd1);
      if (cnt_r == 3'(REM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign remainder = rem_r[7:0];

endmodule
`default_nettype wire

@@ design/mbm_dp.sv @@
// ----------------------------------------------------------------------------
// mbm_dp
// Mapper datapath: register file, address translation, scanline counter.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mbm_pkg::cmd_t cmd,
  output mbm_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [8:0]    cfg_wdata,
  input  wire logic [1:0]    in_mode,
  input  wire logic [15:0]   in_address,
  input  wire logic [7:0]    in_write_data,
  input  wire logic [8:0]    in_dot,
  input  wire logic [8:0]    in_scanline,
  input  wire logic          in_background_on,
  input  wire logic          in_sprites_on,
  input  wire logic          in_cpu_irq_masked,
  output logic [2:0]         out_target,
  output logic [18:0]        out_mem_address,
  output logic               out_irq_fire,
  output logic               out_mirror_horizontal
);

  // configuration
  logic [6:0] prg_banks_r;
  logic [8:0] chr_kib_r;
  logic [6:0] prg_mod_r;
  logic [8:0] chr_mod_r;

  // mapper state
  logic [7:0] bank_r [8];
  logic [2:0] sel_r;
  logic       chr_inv_r, prg_swap_r, mirror_r;
  logic [7:0] protect_r, reload_r, count_r;
  logic       armed_r;

  // captured item
  logic [1:0]  mode_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [8:0]  dot_r, line_r;
  logic        bg_r, spr_r, masked_r;

  // output register
  logic [2:0]  tgt_r;
  logic [18:0] ma_r;
  logic        irq_r, mir_r;

  // remainder unit hookup
  logic       rem_done;
  logic [7:0] rem_val;
  logic [7:0] rem_dividend;
  logic [8:0] rem_divisor;
  logic       rem_zero;

  logic       is_reg_wr;
  logic [2:0] win3;

  // translation
  logic [2:0]  tgt_c;
  logic [18:0] ma_c;
  logic        use_chr, use_prg;
  logic [2:0]  eslot;
  logic        two_k;
  logic [2:0]  ridx;
  logic [7:0]  cbank;
  logic [10:0] cdiff;
  logic [18:0] cvt;
  logic [6:0]  banks_eff;
  logic [6:0]  banks_m1, banks_m2;
  logic [1:0]  win;
  logic        fixed_penult;
  logic [7:0]  pbank;

  // tick
  logic tick_qual;
  logic fire_c;

  assign is_reg_wr = (mode_r == mbm_pkg::MODE_CPU_WR) && addr_r[15];
  assign win3 = addr_r[15:13];
  assign sts.bank_write = is_reg_wr && (win3 == mbm_pkg::WIN_BANK) && addr_r[0];
  assign sts.rem_done = rem_done;

  // bank number before the modulus
  always_comb begin
    if (sel_r[2] && sel_r[1]) begin
      rem_dividend = {2'b00, data_r[5:0]};
      rem_divisor = {2'b00, prg_mod_r};
    end else begin
      rem_dividend = (sel_r[2:1] == 2'b00) ? {data_r[7:1], 1'b0} : data_r;
      rem_divisor = chr_mod_r;
    end
    rem_zero = (rem_divisor == '0);
  end

  mbm_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // pattern and prg translation
  always_comb begin
    tgt_c = mbm_pkg::TGT_NONE;
    ma_c = '0;
    eslot = addr_r[12:10] ^ {chr_inv_r, 2'b00};
    two_k = !eslot[2];
    ridx = two_k ? {2'b00, eslot[1]} : 3'(eslot - 3'd2);
    cbank = bank_r[ridx];
    if (two_k) begin
      cbank[0] = 1'b0;
    end
    cdiff = two_k ? addr_r[10:0] : {1'b0, addr_r[9:0]};
    cvt = {1'b0, cbank, 10'd0} + {8'd0, cdiff};
    banks_eff = (prg_banks_r > mbm_pkg::PRG_BANKS_MAX) ? mbm_pkg::PRG_BANKS_MAX
                                                      : prg_banks_r;
    banks_m1 = 7'(banks_eff - 7'd1);
    banks_m2 = 7'(banks_eff - 7'd2);
    win = addr_r[14:13];
    fixed_penult = ((win == 2'd0) && prg_swap_r) || ((win == 2'd2) && !prg_swap_r);
    pbank = (win == 2'd1) ? bank_r[7] : bank_r[6];
    use_chr = ((mode_r == mbm_pkg::MODE_PPU_PAT) || (mode_r == mbm_pkg::MODE_CPU_RD)
               || (mode_r == mbm_pkg::MODE_CPU_WR)) && (addr_r[15:13] == 3'b000);
    use_prg = (mode_r == mbm_pkg::MODE_CPU_RD) && addr_r[15];
    if (use_chr) begin
      if (chr_kib_r == '0) begin
        tgt_c = mbm_pkg::TGT_CHR_RAM;
        ma_c = {6'd0, addr_r[12:0]};
      end else if (cbank == 8'd8 || cbank == 8'd9) begin
        tgt_c = mbm_pkg::TGT_NT_RAM;
        ma_c = {8'd0, cbank[0], addr_r[9:0]};
      end else begin
        tgt_c = mbm_pkg::TGT_CHR_ROM;
        ma_c = (cvt >= {chr_kib_r, 10'd0}) ? '0 : cvt;
      end
    end else if (use_prg) begin
      if (win == 2'd3) begin
        if (banks_eff != '0) begin
          tgt_c = mbm_pkg::TGT_PRG_ROM;
          ma_c = {banks_m1[5:0], addr_r[12:0]};
        end
      end else if (fixed_penult) begin
        if (banks_eff >= 7'd2) begin
          tgt_c = mbm_pkg::TGT_PRG_ROM;
          ma_c = {banks_m2[5:0], addr_r[12:0]};
        end
      end else if ({1'b0, banks_eff} > pbank) begin
        tgt_c = mbm_pkg::TGT_PRG_ROM;
        ma_c = {pbank[5:0], addr_r[12:0]};
      end
    end else if (mode_r != mbm_pkg::MODE_PPU_PAT && mode_r != mbm_pkg::MODE_TICK
                 && addr_r[15:13] == 3'b011) begin
      tgt_c = mbm_pkg::TGT_PRG_RAM;
      ma_c = {6'd0, addr_r[12:0]};
    end
  end

  // scanline counter qualification
  assign tick_qual = (mode_r == mbm_pkg::MODE_TICK) && (dot_r == mbm_pkg::IRQ_DOT)
                     && !((line_r >= mbm_pkg::VBL_FIRST) && (line_r <= mbm_pkg::VBL_LAST))
                     && (bg_r || spr_r);
  assign fire_c = tick_qual && (count_r == 8'd1) && armed_r && !masked_r;

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_banks_r <= 7'd64;
      chr_kib_r <= 9'd0;
      prg_mod_r <= 7'd64;
      chr_mod_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbm_pkg::CFG_PRG_ROM_BANKS: prg_banks_r <= cfg_wdata[6:0];
        mbm_pkg::CFG_CHR_ROM_KIB:   chr_kib_r <= cfg_wdata;
        mbm_pkg::CFG_PRG_BANK_MOD:  prg_mod_r <= cfg_wdata[6:0];
        mbm_pkg::CFG_CHR_BANK_MOD:  chr_mod_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item capture and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      addr_r <= in_address;
      data_r <= in_write_data;
      dot_r <= in_dot;
      line_r <= in_scanline;
      bg_r <= in_background_on;
      spr_r <= in_sprites_on;
      masked_r <= in_cpu_irq_masked;
    end
    if (cmd.exec) begin
      tgt_r <= tgt_c;
      ma_r <= ma_c;
      irq_r <= fire_c;
      mir_r <= (is_reg_wr && win3 == mbm_pkg::WIN_MIRROR && !addr_r[0]) ? data_r[0]
                                                                        : mirror_r;
    end else if (cmd.rem_finish) begin
      tgt_r <= mbm_pkg::TGT_NONE;
      ma_r <= '0;
      irq_r <= 1'b0;
      mir_r <= mirror_r;
    end
  end

  // mapper state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        bank_r[i] <= '0;
      end
      sel_r <= '0;
      chr_inv_r <= 1'b0;
      prg_swap_r <= 1'b0;
      mirror_r <= 1'b0;
      protect_r <= '0;
      reload_r <= '0;
      count_r <= '0;
      armed_r <= 1'b0;
    end else if (cmd.rem_finish) begin
      bank_r[sel_r] <= rem_zero ? 8'd0 : rem_val;
    end else if (cmd.exec) begin
      if (is_reg_wr) begin
        unique case (win3)
          mbm_pkg::WIN_IRQ_EN: armed_r <= addr_r[0];
          mbm_pkg::WIN_IRQ_LATCH: begin
            if (addr_r[0]) begin
              count_r <= '0;
            end else begin
              reload_r <= data_r;
            end
          end
          mbm_pkg::WIN_MIRROR: begin
            if (addr_r[0]) begin
              protect_r <= data_r;
            end else begin
              mirror_r <= data_r[0];
            end
          end
          default: begin
            if (!addr_r[0]) begin
              chr_inv_r <= data_r[7];
              prg_swap_r <= data_r[6];
              sel_r <= data_r[2:0];
            end
          end
        endcase
      end else if (tick_qual) begin
        count_r <= (count_r == '0) ? reload_r : 8'(count_r - 8'd1);
      end
    end
  end

  assign out_target = tgt_r;
  assign out_mem_address = ma_r;
  assign out_irq_fire = irq_r;
  assign out_mirror_horizontal = mir_r ^ (protect_r != protect_r);

endmodule
`default_nettype wire

@@ design/mbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbm_ctrl
// Controller: input handshake, sequencing of bank writes, output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module mbm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mbm_pkg::cmd_t      cmd,
  input  wire mbm_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REM
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.bank_write) begin
          cmd.rem_start = 1'b1;
          state_nxt = S_REM;
        end else if (out_free) begin
          cmd.exec = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REM: begin
        if (sts.rem_done && out_free) begin
          cmd.rem_finish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ design/mmc3_style_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// mmc3_style_bank_mapper
// Cartridge bank mapper with an MMC3-style register set.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one bus event (cpu read, cpu write, ppu pattern access or
//   dot tick); a transfer happens when in_valid is high and in_stall low.
//   out_* returns exactly one result per event, transferred when out_valid
//   is high and out_stall low. The cfg_* port writes the size and modulus
//   registers; the user must write them only while the block is idle, which
//   the block does not enforce. A plain event is captured; in the execute
//   state its result is registered and out_valid raised once the output is
//   free, and only then is the next event taken. A bank-number write (odd
//   address in 8000-9FFF) runs the bit-serial remainder unit, and its result
//   is registered once the remainder is done and the output is free.
//   While a result waits under out_stall, the next event is still taken and
//   held until the output register frees up.
//   Reset (rst_n low, synchronous) clears all mapper registers to zero and
//   restores the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module mmc3_style_bank_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [8:0]  in_dot,
  input  wire logic [8:0]  in_scanline,
  input  wire logic        in_background_on,
  input  wire logic        in_sprites_on,
  input  wire logic        in_cpu_irq_masked,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_target,
  output logic [18:0]      out_mem_address,
  output logic             out_irq_fire,
  output logic             out_mirror_horizontal
);

  mbm_pkg::cmd_t cmd;
  mbm_pkg::sts_t sts;

  mbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mbm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_mode               (in_mode),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_dot                (in_dot),
    .in_scanline           (in_scanline),
    .in_background_on      (in_background_on),
    .in_sprites_on         (in_sprites_on),
    .in_cpu_irq_masked     (in_cpu_irq_masked),
    .out_target            (out_target),
    .out_mem_address       (out_mem_address),
    .out_irq_fire          (out_irq_fire),
    .out_mirror_horizontal (out_mirror_horizontal)
  );

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("event taken while another is in flight");

  // an irq only comes with a tick, which maps to nothing
  a_irq_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_fire) |-> (out_target == mbm_pkg::TGT_NONE))
    else $error("irq raised on a mapped access");

  // no target means a zero address
  a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_target == mbm_pkg::TGT_NONE) |-> (out_mem_address == '0))
    else $error("nonzero address with no target");

endmodule
`default_nettype wire
